>>> sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One classified character, as it travels from the front to the back.
   typedef struct packed {
      logic [5:0] sextet;      // value in the alphabet, meaningful when in_alphabet
      logic       in_alphabet; // character maps to a sextet
      logic       skippable;   // whitespace that may be dropped at a group start
      logic       last;        // final character of the message
   } b64d_entry_type;

endpackage

>>> sv/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d channel interfaces
// Valid/ready channels for characters, decoded results and the mode register.
// ----------------------------------------------------------------------------
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_message;

   modport source (output valid, output char_code, output end_of_message, input ready);
   modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       message_end;
   logic       stopped;

   modport source (output valid, output out_byte, output byte_valid,
                   output message_end, output stopped, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input message_end, input stopped, output ready);
endinterface

interface b64d_csr_if;
   logic valid;
   logic ready;
   logic url_alphabet;

   modport source (output valid, output url_alphabet, input ready);
   modport sink   (input valid, input url_alphabet, output ready);
endinterface

>>> sv/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accept character beats and classify each against the selected alphabet.
// ----------------------------------------------------------------------------
module b64d_front
   import b64d_pkg::*;
(
   input  logic           reset,
   b64d_req_if.sink       req_ch,
   input  logic           url_alphabet,
   input  logic           queue_full,
   output logic           push,
   output b64d_entry_type push_entry
);

   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_UNDER    = 8'h5F;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] LOWER_BIAS  = 8'h47;  // 'a' - 26
   localparam logic [7:0] DIGIT_BIAS  = 8'h04;  // 52 - '0'
   localparam logic [5:0] SEXTET_62   = 6'd62;
   localparam logic [5:0] SEXTET_63   = 6'd63;

   logic [7:0] ch;
   logic [7:0] diff;
   logic [7:0] code_62;
   logic [7:0] code_63;

   assign ch      = req_ch.char_code;
   assign code_62 = url_alphabet ? CH_MINUS : CH_PLUS;
   assign code_63 = url_alphabet ? CH_UNDER : CH_SLASH;

   always_comb begin
      diff                   = 8'd0;
      push_entry.sextet      = 6'd0;
      push_entry.in_alphabet = 1'b1;
      if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         diff              = ch - CH_UPPER_A;
         push_entry.sextet = diff[5:0];
      end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
         diff              = ch - LOWER_BIAS;
         push_entry.sextet = diff[5:0];
      end else if (ch inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
         diff              = ch + DIGIT_BIAS;
         push_entry.sextet = diff[5:0];
      end else if (ch == code_62) begin
         push_entry.sextet = SEXTET_62;
      end else if (ch == code_63) begin
         push_entry.sextet = SEXTET_63;
      end else begin
         push_entry.in_alphabet = 1'b0;
      end
      // whitespace skip exists in standard mode only
      push_entry.skippable = !url_alphabet &&
                             ((ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]}));
      push_entry.last      = req_ch.end_of_message;
   end

   // Hold the channel while the queue has no room or reset is asserted.
   assign req_ch.ready = !queue_full && !reset;
   assign push         = req_ch.valid && req_ch.ready;

endmodule

>>> sv/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short FIFO of classified characters between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue
   import b64d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  b64d_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output b64d_entry_type head_entry
);

   b64d_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff;
   logic [QUEUE_AW-1:0]     wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff;
   logic [QUEUE_AW-1:0]     rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff;
   logic [QUEUE_AW:0]       count_in;
   logic                    do_pop;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Advance the group state per character and register the decoded result.
// ----------------------------------------------------------------------------
module b64d_back
   import b64d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  b64d_entry_type head_entry,
   output logic           pop,
   b64d_rsp_if.source     rsp_ch
);

   logic [1:0] position_ff;
   logic [1:0] position_in;
   logic [5:0] prev_ff;
   logic [5:0] prev_in;
   logic       halted_ff;
   logic       halted_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       byte_valid_ff;
   logic       last_ff;
   logic       stopped_ff;

   logic       have_byte;
   logic       newly_halted;
   logic       emit;
   logic       out_free;

   always_comb begin
      have_byte    = 1'b0;
      newly_halted = 1'b0;
      byte_in      = 8'd0;
      position_in  = position_ff;
      prev_in      = prev_ff;
      halted_in    = halted_ff;
      if (!halted_ff) begin
         if (head_entry.skippable && (position_ff == 2'd0)) begin
            // drop the whitespace, stay at group start
         end else if (!head_entry.in_alphabet) begin
            halted_in    = 1'b1;
            newly_halted = 1'b1;
         end else begin
            case (position_ff)
               2'd1: begin
                  byte_in   = {prev_ff, head_entry.sextet[5:4]};
                  have_byte = 1'b1;
               end
               2'd2: begin
                  byte_in   = {prev_ff[3:0], head_entry.sextet[5:2]};
                  have_byte = 1'b1;
               end
               2'd3: begin
                  byte_in   = {prev_ff[1:0], head_entry.sextet};
                  have_byte = 1'b1;
               end
               default: begin
                  byte_in = 8'd0;
               end
            endcase
            prev_in     = head_entry.sextet;
            position_in = position_ff + 1'b1;
         end
      end
      emit = have_byte || head_entry.last || newly_halted;
   end

   // Output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop      = head_valid && (!emit || out_free);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= 2'd0;
         prev_ff      <= 6'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (head_entry.last) begin
               position_ff <= 2'd0;
               prev_ff     <= 6'd0;
               halted_ff   <= 1'b0;
            end else begin
               position_ff <= position_in;
               prev_ff     <= prev_in;
               halted_ff   <= halted_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         byte_ff       <= byte_in;
         byte_valid_ff <= have_byte;
         last_ff       <= head_entry.last;
         stopped_ff    <= halted_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.byte_valid  = byte_valid_ff;
   assign rsp_ch.message_end = last_ff;
   assign rsp_ch.stopped     = stopped_ff;

endmodule

>>> sv/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 decoder, one character beat in, zero or one byte beat out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one character per beat (char_code, end_of_message).
//   rsp_ch carries a result beat when a byte is decoded, when a character
//   newly stops decoding, or for the last character of a message.
//   csr_ch sets url_alphabet (0 standard, group-start whitespace skip, 1
//   URL-safe), always ready; the user writes it only while idle, unenforced.
// Timing:
//   One character per cycle while the queue has room. A result beat passes
//   through the classifier queue and then the back end's output register
//   before it is valid on rsp_ch.
// Reset (synchronous): group state cleared, queue emptied, url_alphabet 0.
// Stall: when rsp_ch is held, the back end pops only beat-free characters;
//   the four-entry queue absorbs the rest until full, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_ch,
   b64d_rsp_if.source rsp_ch,
   b64d_csr_if.sink   csr_ch
);

   logic           url_alphabet_ff;
   logic           url_alphabet_in;
   logic           queue_full;
   logic           push;
   b64d_entry_type push_entry;
   logic           pop;
   logic           head_valid;
   b64d_entry_type head_entry;

   // Mode register: take every write beat.
   assign csr_ch.ready    = 1'b1;
   assign url_alphabet_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.url_alphabet
                                                           : url_alphabet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_alphabet_ff <= 1'b0;
      end else begin
         url_alphabet_ff <= url_alphabet_in;
      end
   end

   // Front: classify each character beat and push it.
   b64d_front u_front (
      .reset        (reset),
      .req_ch       (req_ch),
      .url_alphabet (url_alphabet_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Queue: decouple classification from the stateful back end.
   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back: advance group state, drive the result beat.
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

>>> tb/sv/b64d_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_decode_checker
// Watches the character, result and mode channels of the Base64 decoder,
// predicts each result beat from the accepted characters and compares.
// ----------------------------------------------------------------------------
module b64d_decode_checker (
   input  logic clock,
   input  logic reset,
   b64d_req_if  req_ch,
   b64d_rsp_if  rsp_ch,
   b64d_csr_if  csr_ch,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       message_end;
      logic       stopped;
   } decoded_beat_type;

   // Decoder state as the block should hold it.
   logic             url_mode;
   logic [1:0]       group_pos;
   logic [5:0]       prev_sextet;
   logic             halted;
   decoded_beat_type decoded_q[$];
   int               errors  = 0;
   int               pending = 0;

   assign fail_count    = errors;
   assign pending_count = pending;

   // Advance the decoder state by one character; emits says whether a beat is due.
   function automatic void decode_char(input logic [7:0] ch, input logic eom,
                                       output logic emits, output decoded_beat_type beat);
      logic [5:0] s;
      logic       mapped;
      logic       newly_halted;
      beat         = '0;
      newly_halted = 1'b0;
      mapped       = 1'b1;
      s            = '0;
      if (ch >= "A" && ch <= "Z")
         s = 6'(ch - "A");
      else if (ch >= "a" && ch <= "z")
         s = 6'(ch - "a" + 8'd26);
      else if (ch >= "0" && ch <= "9")
         s = 6'(ch - "0" + 8'd52);
      else if (ch == (url_mode ? "-" : "+"))
         s = 6'd62;
      else if (ch == (url_mode ? "_" : "/"))
         s = 6'd63;
      else
         mapped = 1'b0;

      if (!halted) begin
         if (!url_mode && group_pos == 2'd0 &&
             (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D))) begin
            // whitespace at a group start: drop it, position stays
         end else if (!mapped) begin
            halted       = 1'b1;
            newly_halted = 1'b1;
         end else begin
            case (group_pos)
               2'd1: beat.out_byte = {prev_sextet, s[5:4]};
               2'd2: beat.out_byte = {prev_sextet[3:0], s[5:2]};
               2'd3: beat.out_byte = {prev_sextet[1:0], s};
               default: beat.out_byte = 8'h00;
            endcase
            beat.byte_valid = (group_pos != 2'd0);
            prev_sextet     = s;
            group_pos       = group_pos + 2'd1;
         end
      end

      emits            = beat.byte_valid || eom || newly_halted;
      beat.message_end = eom;
      beat.stopped     = halted;
      if (eom) begin
         group_pos   = '0;
         prev_sextet = '0;
         halted      = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      decoded_beat_type got;
      decoded_beat_type want;
      decoded_beat_type next_beat;
      logic             emits;
      if (reset) begin
         url_mode    = 1'b0;
         group_pos   = '0;
         prev_sextet = '0;
         halted      = 1'b0;
         decoded_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready)
            url_mode = csr_ch.url_alphabet;

         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.message_end, rsp_ch.stopped};
            if (decoded_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, expected none actual %h", $time, got);
            end else begin
               want = decoded_q.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  errors++;
                  $display("%0t: out_byte expected %h actual %h",
                           $time, want.out_byte, got.out_byte);
               end
               if (got.byte_valid !== want.byte_valid) begin
                  errors++;
                  $display("%0t: byte_valid expected %b actual %b",
                           $time, want.byte_valid, got.byte_valid);
               end
               if (got.message_end !== want.message_end) begin
                  errors++;
                  $display("%0t: message_end expected %b actual %b",
                           $time, want.message_end, got.message_end);
               end
               if (got.stopped !== want.stopped) begin
                  errors++;
                  $display("%0t: stopped expected %b actual %b",
                           $time, want.stopped, got.stopped);
               end
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            decode_char(req_ch.char_code, req_ch.end_of_message, emits, next_beat);
            if (emits)
               decoded_q.push_back(next_beat);
         end
      end
      pending = decoded_q.size();
   end

endmodule

>>> tb/sv/tb_base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_top
// Drives character messages into the Base64 stream decoder in both alphabet
// modes, with random idle bursts on both channels, a long result stall and
// mode changes between phases; a checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_top;

   localparam logic MODE_STANDARD = 1'b0;
   localparam logic MODE_URL      = 1'b1;

   // Message shapes for the random part.
   localparam int MSG_NOISE   = 0;
   localparam int MSG_CORRUPT = 1;
   localparam int MSG_PADDED  = 2;

   localparam int ITEM_COUNT  = 1950;
   localparam int PHASE_ITEMS = 150;
   localparam int CALM_ITEMS  = 250;    // final stretch without idling
   localparam int LONG_HOLD   = 80;     // cycles of result back-pressure
   localparam int DRAIN_TAIL  = 12;     // queue depth plus output register, with margin
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset;
   logic cur_mode;
   bit   calm           = 1'b0;
   bit   long_hold_req  = 1'b0;
   bit   long_hold_done = 1'b0;
   int   sent           = 0;
   int   cycle_count    = 0;
   int   fail_count;
   int   pending_count;

   b64d_req_if req_ch ();
   b64d_rsp_if rsp_ch ();
   b64d_csr_if csr_ch ();

   base64_stream_decoder_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   b64d_decode_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // Offer one character beat and hold it until the block takes it. Valid is
   // left high afterwards, so back-to-back beats drop it only for a random idle burst.
   task automatic send_char(input logic [7:0] ch, input logic eom);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.char_code      <= ch;
      req_ch.end_of_message <= eom;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   // Drop valid, wait for every predicted beat, then let trailing characters
   // that produce no beat leave the queue.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // Write the mode register; callers make sure the block is idle.
   task automatic write_mode(input logic mode);
      csr_ch.valid        <= 1'b1;
      csr_ch.url_alphabet <= mode;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      cur_mode = mode;
   endtask

   // Send one message: mostly clean text in the current alphabet, sometimes
   // with whitespace at group starts, padding at the tail, one corrupt
   // character, or nothing but raw bytes. len_hint of 0 picks a random size.
   task automatic send_message(input int len_hint);
      int          len;
      int          kind;
      int          bad_at;
      int          k;
      int          w;
      logic [7:0]  ch;
      logic [5:0]  v;
      len = len_hint;
      if (len == 0)
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      kind   = $urandom_range(0, 9);
      bad_at = $urandom_range(0, len - 1);
      for (k = 0; k < len; k++) begin
         v = 6'($urandom_range(0, 63));
         if (v < 26)
            ch = "A" + v;
         else if (v < 52)
            ch = "a" + (v - 26);
         else if (v < 62)
            ch = "0" + (v - 52);
         else if (v == 62)
            ch = (cur_mode == MODE_URL) ? "-" : "+";
         else
            ch = (cur_mode == MODE_URL) ? "_" : "/";

         if (kind == MSG_NOISE || (kind == MSG_CORRUPT && k == bad_at))
            ch = 8'($urandom_range(0, 255));
         else if (kind == MSG_PADDED && k > 0 && k >= len - 2)
            ch = "=";

         // whitespace ahead of a group: skipped in standard mode
         if (cur_mode == MODE_STANDARD && k % 4 == 0 && $urandom_range(0, 5) == 0) begin
            w = $urandom_range(8, 13);
            send_char((w == 8) ? 8'h20 : w[7:0], 1'b0);
         end
         send_char(ch, k == len - 1);
      end
   endtask

   // Result side: random back-pressure bursts, plus one long hold on request
   // so that the four-entry queue fills and character beats stall.
   initial begin
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Hard stop if the run hangs, e.g. a predicted beat never arrives.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result beats outstanding", $time, pending_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int phase;
      int phase_start;
      req_ch.valid          <= 1'b0;
      req_ch.char_code      <= 8'h00;
      req_ch.end_of_message <= 1'b0;
      csr_ch.valid          <= 1'b0;
      csr_ch.url_alphabet   <= MODE_STANDARD;
      reset                 <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, standard alphabet --------------------------------
      write_mode(MODE_STANDARD);
      // every whitespace code at a group start, then the lowest and highest
      // sextets, closing on a full group
      send_char(8'h20, 1'b0); send_char(8'h09, 1'b0); send_char(8'h0A, 1'b0);
      send_char(8'h0B, 1'b0); send_char(8'h0C, 1'b0); send_char(8'h0D, 1'b0);
      send_char("A", 1'b0);   send_char("/", 1'b0);   send_char("+", 1'b0);
      send_char("z", 1'b1);
      // padding halts; the marked last character still reports stopped
      send_char("9", 1'b0);   send_char("0", 1'b0);   send_char("=", 1'b0);
      send_char("Q", 1'b1);
      // whitespace inside a group halts; ends on an all-ones character code
      send_char("a", 1'b0);   send_char(8'h20, 1'b0); send_char(8'hFF, 1'b1);
      // single-character message that halts and ends at once
      send_char(8'h00, 1'b1);

      // ---- directed part, URL-safe alphabet --------------------------------
      wait_drained();
      write_mode(MODE_URL);
      // '-' and '_' decode, '+' halts, trailing whitespace ends the message
      send_char("-", 1'b0);   send_char("_", 1'b0);   send_char("Z", 1'b0);
      send_char("+", 1'b0);   send_char(8'h20, 1'b1);
      // whitespace at a group start is not skipped here
      send_char(8'h09, 1'b1);

      // ---- random part -----------------------------------------------------
      // Each phase starts idle: drain, pick a mode, then stream messages.
      // Phase 0 and 1 pin both register values; phase 2 carries the long
      // result stall under a long message.
      for (phase = 0; sent < ITEM_COUNT; phase++) begin
         wait_drained();
         calm = (sent >= ITEM_COUNT - CALM_ITEMS);
         if (phase == 0)
            write_mode(MODE_URL);
         else if (phase == 1)
            write_mode(MODE_STANDARD);
         else
            write_mode(1'($urandom_range(0, 1)));
         phase_start = sent;
         if (phase == 2) begin
            long_hold_req = 1'b1;
            send_message(40);
         end
         while (sent - phase_start < PHASE_ITEMS && sent < ITEM_COUNT)
            send_message(0);
      end

      wait_drained();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
